// File: rtl/bakery_ticket_lock_arbiter_macros.svh
// Assertion macros shared by the bakery ticket lock arbiter RTL
`ifndef BAKERY_TICKET_LOCK_ARBITER_MACROS_SVH
`define BAKERY_TICKET_LOCK_ARBITER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define BKL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define BKL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bkl_pkg.sv
// Package: sizes, codes and scan token type of the bakery ticket lock arbiter
`default_nettype none

package bkl_pkg;

    localparam int MAX_THREADS  = 8;
    localparam int TICKET_BITS  = 16;

    localparam int THREAD_ID_W  = 3;
    localparam int ASSIGNED_W   = 16;
    localparam int STATUS_W     = 2;
    localparam int CFG_W        = 4;

    localparam int IDX_W        = $clog2(MAX_THREADS);
    localparam int CNT_W        = $clog2(MAX_THREADS + 1);
    localparam int CMP_W        = (CNT_W > THREAD_ID_W) ? CNT_W : THREAD_ID_W;
    localparam int CFGCMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [TICKET_BITS-1:0] TICKET_LIMIT = {TICKET_BITS{1'b1}};

    localparam int RESET_THREADS = 8;
    localparam logic [CNT_W-1:0] RESET_CNT =
        CNT_W'((RESET_THREADS > MAX_THREADS) ? MAX_THREADS : RESET_THREADS);

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic                   vld;
        logic [TICKET_BITS-1:0] top;
        logic                   al_found;
        logic [TICKET_BITS-1:0] al_min;
        logic [IDX_W-1:0]       al_idx;
        logic                   ex_found;
        logic [TICKET_BITS-1:0] ex_min;
        logic [IDX_W-1:0]       ex_idx;
    } scan_t;

    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       idx;
        logic [TICKET_BITS-1:0] value;
    } tkt_wr_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] raw);
        logic [CFGCMP_W-1:0] wide;
        wide = CFGCMP_W'(raw);
        if (wide == '0)
            return CNT_W'(1);
        else if (wide > CFGCMP_W'(MAX_THREADS))
            return CNT_W'(MAX_THREADS);
        else
            return CNT_W'(wide);
    endfunction

endpackage

`default_nettype wire

// File: rtl/bkl_cell.sv
// One thread slot: holds its ticket and folds it into the passing scan token
`default_nettype none

module bkl_cell
    import bkl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [IDX_W-1:0]       cell_idx,
    input  wire logic [CNT_W-1:0]       count,
    input  wire logic [THREAD_ID_W-1:0] tid,
    input  wire tkt_wr_t                wr,
    input  wire scan_t                  scan_in,
    output scan_t                       scan_out
);

    logic [TICKET_BITS-1:0] ticket_reg;
    logic [TICKET_BITS-1:0] ticket_next;
    scan_t                  scan_reg;
    scan_t                  scan_next;
    logic                   active;
    logic                   is_tid;

    assign active = CNT_W'(cell_idx) < count;
    assign is_tid = CMP_W'(cell_idx) == CMP_W'(tid);

    always_comb
    begin
        scan_next = scan_in;
        if (scan_in.vld && active)
        begin
            if (ticket_reg > scan_in.top)
                scan_next.top = ticket_reg;
            if (ticket_reg != '0)
            begin
                if (!scan_in.al_found || ticket_reg < scan_in.al_min)
                begin
                    scan_next.al_found = 1'b1;
                    scan_next.al_min   = ticket_reg;
                    scan_next.al_idx   = cell_idx;
                end
                if (!is_tid && (!scan_in.ex_found || ticket_reg < scan_in.ex_min))
                begin
                    scan_next.ex_found = 1'b1;
                    scan_next.ex_min   = ticket_reg;
                    scan_next.ex_idx   = cell_idx;
                end
            end
        end
    end

    always_comb
    begin
        ticket_next = ticket_reg;
        if (wr.en && wr.idx == cell_idx)
            ticket_next = wr.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticket_reg <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            ticket_reg <= ticket_next;
            scan_reg   <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

`default_nettype wire

// File: rtl/bakery_ticket_lock_arbiter.sv
// Top level: bakery ticket lock arbiter built from a row of thread slot cells
//
// Usage:
//   Command channel: raise start with kind (0 acquire, 1 release) and
//   thread_id; the command transfers at a rising edge where start is high
//   and busy is low. busy stays high while the command is in flight.
//   Result channel: done is high for exactly one cycle with holder_valid,
//   holder_thread, assigned_ticket and status. The receiver cannot stall;
//   the result must be taken in that cycle.
//   Configuration: cfg_data sets the active thread count; it transfers when
//   cfg_valid and cfg_ready are high. cfg_ready is low while busy or start.
//   Sequence: an accepted command sets launch_reg, the scan token walks the row
//   of cells, one slot per cycle, and the result registers take the tail of
//   the row, raising done. No new command transfers while busy is high; one
//   may transfer in the cycle done is high.
//   Reset: all tickets clear, active count returns to eight, nothing in
//   flight. No clearing pass is needed after reset.
`default_nettype none

`include "bakery_ticket_lock_arbiter_macros.svh"

module bakery_ticket_lock_arbiter
    import bkl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   kind,
    input  wire logic [THREAD_ID_W-1:0] thread_id,
    output logic                        done,
    output logic                        holder_valid,
    output logic [THREAD_ID_W-1:0]      holder_thread,
    output logic [ASSIGNED_W-1:0]       assigned_ticket,
    output logic [STATUS_W-1:0]         status,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    logic                   busy_reg;
    logic                   busy_next;
    logic                   launch_reg;
    logic                   kind_reg;
    logic [THREAD_ID_W-1:0] tid_reg;
    logic                   range_ok_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   done_reg;
    logic                   hv_reg;
    logic                   hv_next;
    logic [THREAD_ID_W-1:0] ht_reg;
    logic [THREAD_ID_W-1:0] ht_next;
    logic [ASSIGNED_W-1:0]  at_reg;
    logic [ASSIGNED_W-1:0]  at_next;
    logic [STATUS_W-1:0]    st_reg;
    logic [STATUS_W-1:0]    st_next;
    logic                   accept;
    scan_t                  chain [0:MAX_THREADS];
    scan_t                  tail;
    tkt_wr_t                wr;
    logic [MAX_THREADS:0]   token_vld;

    assign accept    = start && !busy_reg;
    assign cfg_ready = !busy_reg && !start;
    assign tail      = chain[MAX_THREADS];

    always_comb
    begin
        chain[0]     = '0;
        chain[0].vld = launch_reg;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_THREADS; g++)
        begin : g_cell
            bkl_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDX_W'(g)),
                .count    (cnt_reg),
                .tid      (tid_reg),
                .wr       (wr),
                .scan_in  (chain[g]),
                .scan_out (chain[g+1])
            );
            assign token_vld[g] = chain[g+1].vld;
        end
    endgenerate

    assign token_vld[MAX_THREADS] = launch_reg;

    always_comb
    begin
        wr       = '0;
        wr.idx   = IDX_W'(tid_reg);
        hv_next  = tail.al_found;
        ht_next  = THREAD_ID_W'(tail.al_idx);
        at_next  = '0;
        st_next  = ST_OK;
        if (!range_ok_reg)
        begin
            st_next = ST_RANGE;
        end
        else if (kind_reg == KIND_ACQUIRE)
        begin
            if (tail.top == TICKET_LIMIT)
            begin
                st_next = ST_OVERFLOW;
            end
            else
            begin
                wr.en    = tail.vld;
                wr.value = tail.top + TICKET_BITS'(1);
                at_next  = ASSIGNED_W'(wr.value);
                hv_next  = 1'b1;
                ht_next  = tail.ex_found ? THREAD_ID_W'(tail.ex_idx) : tid_reg;
            end
        end
        else
        begin
            wr.en   = tail.vld;
            hv_next = tail.ex_found;
            ht_next = THREAD_ID_W'(tail.ex_idx);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (tail.vld)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            launch_reg   <= 1'b0;
            done_reg     <= 1'b0;
            cnt_reg      <= RESET_CNT;
            kind_reg     <= KIND_ACQUIRE;
            tid_reg      <= '0;
            range_ok_reg <= 1'b0;
            hv_reg       <= 1'b0;
            ht_reg       <= '0;
            at_reg       <= '0;
            st_reg       <= ST_OK;
        end
        else
        begin
            busy_reg   <= busy_next;
            launch_reg <= accept;
            done_reg   <= tail.vld;
            if (cfg_valid && cfg_ready)
                cnt_reg <= eff_count(cfg_data);
            if (accept)
            begin
                kind_reg     <= kind;
                tid_reg      <= thread_id;
                range_ok_reg <= CMP_W'(thread_id) < CMP_W'(cnt_reg);
            end
            if (tail.vld)
            begin
                hv_reg <= hv_next;
                ht_reg <= ht_next;
                at_reg <= at_next;
                st_reg <= st_next;
            end
        end
    end

    assign busy            = busy_reg;
    assign done            = done_reg;
    assign holder_valid    = hv_reg;
    assign holder_thread   = ht_reg;
    assign assigned_ticket = at_reg;
    assign status          = st_reg;

    `BKL_ASSERT_NOW(a_done_idle, done_reg, !busy_reg, "result strobe while busy")
    `BKL_ASSERT_NOW(a_tail_busy, tail.vld, busy_reg, "scan token finished while idle")
    `BKL_ASSERT_NOW(a_one_token, 1'b1, $onehot0(token_vld), "more than one scan token in flight")
    `BKL_ASSERT_NOW(a_refused_zero, done_reg && st_reg != ST_OK, at_reg == '0, "ticket on refusal")
    `BKL_ASSERT_NOW(a_no_holder, done_reg && !hv_reg, ht_reg == '0, "holder index without holder")

endmodule

`default_nettype wire
